@@ rtl/bpa_pkg.sv @@
// Shared types and codes for the buddy page allocator.
// Holds the controller states, result status codes and the controller-to-datapath
// command and status structs. Depends on nothing.
package bpa_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOSPACE = 2'd1;
	localparam logic [1:0] STAT_BADFREE = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_A_ROOT,
		S_A_DRD,
		S_A_DCHK,
		S_A_MARK,
		S_F_RD,
		S_F_CHK,
		S_UP_RD,
		S_UP_WR,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_SELF,
		RD_CHILD,
		RD_SIB
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    clr_step;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    desc_step;
		logic    mark_alloc;
		logic    free_mark;
		logic    climb;
		logic    up_step;
		logic    res_nospace;
		logic    res_err;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic op_free;
		logic bad_page;
		logic root_short;
		logic can_desc;
		logic can_desc_next;
		logic rdata_zero;
		logic idx_root;
		logic parent_root;
	} stat_t;

endpackage

@@ rtl/bpa_ctrl.sv @@
// Controller state machine of the buddy page allocator.
// Sequences the tree clear, the allocate descent, the free climb and the shared
// ascent. Depends on bpa_pkg.
module bpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bpa_pkg::stat_t stat,
	output bpa_pkg::cmd_t  cmd,
	output logic          busy,
	output logic          done
);
	import bpa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_START;
			end
			S_START: begin
				if (stat.op_free && stat.bad_page) state_d = S_DONE;
				else if (stat.op_free) state_d = S_F_CHK;
				else state_d = S_A_ROOT;
			end
			S_A_ROOT: begin
				if (stat.root_short) state_d = S_DONE;
				else if (stat.can_desc) state_d = S_A_DRD;
				else state_d = S_A_MARK;
			end
			S_A_DRD: begin
				state_d = S_A_DCHK;
			end
			S_A_DCHK: begin
				state_d = stat.can_desc_next ? S_A_DRD : S_A_MARK;
			end
			S_A_MARK: begin
				state_d = stat.idx_root ? S_DONE : S_UP_RD;
			end
			S_F_RD: begin
				state_d = S_F_CHK;
			end
			S_F_CHK: begin
				if (stat.rdata_zero) state_d = stat.idx_root ? S_DONE : S_UP_RD;
				else if (stat.idx_root) state_d = S_DONE;
				else state_d = S_F_RD;
			end
			S_UP_RD: begin
				state_d = S_UP_WR;
			end
			S_UP_WR: begin
				state_d = stat.parent_root ? S_DONE : S_UP_RD;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		cmd.rd_sel = RD_SELF;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_START: begin
				if (stat.op_free && stat.bad_page) begin
					cmd.res_err = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_SELF;
				end
			end
			S_A_ROOT: begin
				cmd.res_nospace = stat.root_short;
			end
			S_A_DRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_CHILD;
			end
			S_A_DCHK: begin
				cmd.desc_step = 1'b1;
			end
			S_A_MARK: begin
				cmd.mark_alloc = 1'b1;
			end
			S_F_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SELF;
			end
			S_F_CHK: begin
				if (stat.rdata_zero) cmd.free_mark = 1'b1;
				else if (stat.idx_root) cmd.res_err = 1'b1;
				else cmd.climb = 1'b1;
			end
			S_UP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SIB;
			end
			S_UP_WR: begin
				cmd.up_step = 1'b1;
			end
			S_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

@@ rtl/bpa_dp.sv @@
// Datapath of the buddy page allocator: the node memory, the walk registers,
// the clear sweep counters and the result registers. Depends on bpa_pkg.
module bpa_dp #(
	parameter int PAGES = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op,
	input  logic [10:0]    request_pages,
	input  logic [9:0]     page_offset,
	input  bpa_pkg::cmd_t  cmd,
	output bpa_pkg::stat_t stat,
	output logic [1:0]     status,
	output logic [9:0]     block_offset,
	output logic [10:0]    block_pages
);
	import bpa_pkg::*;

	localparam int NODES = 2 * PAGES - 1;
	localparam int AW    = $clog2(NODES);
	localparam int NW    = $clog2(PAGES) + 1;
	localparam int OW    = $clog2(PAGES);
	localparam int WW    = (NW > 12) ? NW : 12;

	// Smallest power of two not below n; zero rounds to one.
	function automatic logic [11:0] round_pow2(input logic [10:0] n);
		logic [10:0] m;
		logic [11:0] p;
		begin
			m = (n == 11'd0) ? 11'd0 : n - 11'd1;
			p = 12'd1;
			for (int k = 0; k < 11; k++) begin
				if (m[k]) p = 12'd1 << (k + 1);
			end
			return p;
		end
	endfunction

	logic [NW-1:0] mem [NODES];
	logic [NW-1:0] rdata_q;

	logic          op_q;
	logic          bad_q;
	logic [WW-1:0] want_q;
	logic [AW-1:0] idx_q;
	logic [NW-1:0] span_q;
	logic [NW-1:0] cur_q;
	logic [OW-1:0] off_q;

	logic [AW-1:0] clr_idx_q;
	logic [NW-1:0] clr_size_q;
	logic [AW:0]   clr_next_q;

	logic [1:0]    status_q;
	logic [9:0]    block_offset_q;
	logic [10:0]   block_pages_q;

	logic [AW-1:0] child_l, sibling, parent, rd_addr, wr_addr, leaf;
	logic [NW-1:0] span_half, par_span, up_val, big, wr_data;
	logic [NW:0]   pair_sum;
	logic          go_left, wr_en;
	logic [WW-1:0] off_w, span_w, page_w;

	assign child_l   = {idx_q[AW-2:0], 1'b1};
	assign sibling   = idx_q[0] ? idx_q + AW'(1) : idx_q - AW'(1);
	assign parent    = (idx_q - AW'(1)) >> 1;
	assign span_half = span_q >> 1;
	assign par_span  = span_q << 1;
	assign go_left   = WW'(rdata_q) >= want_q;
	assign page_w    = WW'(page_offset);
	assign leaf      = AW'(page_w + WW'(PAGES - 1));
	assign off_w     = WW'(off_q);
	assign span_w    = WW'(span_q);

	// Parent refresh: larger child, or a merge of two wholly free buddies on a free.
	assign pair_sum = {1'b0, cur_q} + {1'b0, rdata_q};
	assign big      = (cur_q > rdata_q) ? cur_q : rdata_q;
	assign up_val   = (op_q == OP_FREE && pair_sum == {1'b0, par_span}) ? par_span : big;

	always_comb begin
		case (cmd.rd_sel)
			RD_SELF:  rd_addr = idx_q;
			RD_CHILD: rd_addr = child_l;
			RD_SIB:   rd_addr = sibling;
			default:  rd_addr = idx_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_q;
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_addr = clr_idx_q;
			wr_data = clr_size_q;
		end else if (cmd.mark_alloc) begin
			wr_data = '0;
		end else if (cmd.free_mark) begin
			wr_data = span_q;
		end else if (cmd.up_step) begin
			wr_addr = parent;
			wr_data = up_val;
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_size_q <= NW'(PAGES);
			clr_next_q <= (AW + 1)'(1);
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if ({1'b0, clr_idx_q} + (AW + 1)'(1) == clr_next_q) begin
				clr_size_q <= clr_size_q >> 1;
				clr_next_q <= {clr_next_q[AW-1:0], 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			bad_q  <= page_w >= WW'(PAGES);
			want_q <= WW'(round_pow2(request_pages));
			idx_q  <= (op == OP_FREE) ? leaf : '0;
			span_q <= (op == OP_FREE) ? NW'(1) : NW'(PAGES);
			off_q  <= '0;
		end
		if (cmd.desc_step) begin
			idx_q  <= go_left ? child_l : child_l + AW'(1);
			off_q  <= go_left ? off_q : off_q + OW'(span_half);
			span_q <= span_half;
		end
		if (cmd.mark_alloc) begin
			cur_q          <= '0;
			status_q       <= STAT_OK;
			block_offset_q <= off_w[9:0];
			block_pages_q  <= span_w[10:0];
		end
		if (cmd.free_mark) begin
			cur_q          <= span_q;
			status_q       <= STAT_OK;
			block_offset_q <= '0;
			block_pages_q  <= span_w[10:0];
		end
		if (cmd.climb) begin
			idx_q  <= parent;
			span_q <= par_span;
		end
		if (cmd.up_step) begin
			idx_q  <= parent;
			cur_q  <= up_val;
			span_q <= par_span;
		end
		if (cmd.res_nospace) begin
			status_q       <= STAT_NOSPACE;
			block_offset_q <= '0;
			block_pages_q  <= '0;
		end
		if (cmd.res_err) begin
			status_q       <= STAT_BADFREE;
			block_offset_q <= '0;
			block_pages_q  <= '0;
		end
	end

	assign stat.clr_last      = clr_idx_q == AW'(NODES - 1);
	assign stat.op_free       = op_q == OP_FREE;
	assign stat.bad_page      = bad_q;
	assign stat.root_short    = WW'(rdata_q) < want_q;
	assign stat.can_desc      = (span_w > want_q) && (span_q > NW'(1));
	assign stat.can_desc_next = (WW'(span_half) > want_q) && (span_half > NW'(1));
	assign stat.rdata_zero    = rdata_q == '0;
	assign stat.idx_root      = idx_q == '0;
	assign stat.parent_root   = parent == '0;

	assign status       = status_q;
	assign block_offset = block_offset_q;
	assign block_pages  = block_pages_q;

endmodule

@@ rtl/buddy_page_allocator.sv @@
// Top level of the buddy page allocator: ties the controller to the datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_dp.
//
// A request is taken when start is high while busy is low; it carries op (0 allocate,
// 1 free), request_pages and page_offset. Exactly one result comes back per request:
// done is high for a single cycle with status, block_offset and block_pages valid in
// that same cycle. The receiver cannot stall, so whoever consumes the results must
// capture them on that cycle; the result ports are not guaranteed to mean anything
// at other times. Busy stays high from the cycle after a request is taken until the
// cycle after done, so a new request can be issued the cycle after the strobe.
// The tree of 2*PAGES-1 nodes lives in a single memory with one read port and one
// write port, read data registered, so each tree level going down takes a read state
// and a check state, and each level coming back up a read state and a write state.
// A free climbs from the leaf to the allocated node and then merges back up to the
// root; a free of a page that is not allocated climbs all the way to the root and
// takes as long as a free of an allocated block. An oversized allocate goes from the
// root read straight to done with a no-space status, and a free of a page outside
// the pool goes straight to done with a bad-free status. After reset the block is
// busy while a clearing pass writes every node its initial free size; no request is
// accepted during that time. PAGES must be a power of two.
module buddy_page_allocator #(
	parameter int PAGES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [10:0] request_pages,
	input  logic [9:0]  page_offset,
	output logic        done,
	output logic [1:0]  status,
	output logic [9:0]  block_offset,
	output logic [10:0] block_pages
);
	import bpa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// The controller only sequences; all tree state and arithmetic sit in the datapath.
	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bpa_dp #(
		.PAGES (PAGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.request_pages (request_pages),
		.page_offset   (page_offset),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.block_offset  (block_offset),
		.block_pages   (block_pages)
	);

endmodule
